FILE: rtl/jdi_pkg.sv
// ----------------------------------------------------------------------------
// jdi_pkg: shared types and a table for the 8x8 dequantizing IDCT
// Beat payload types, queue entry type and the zigzag-to-natural table.
// ----------------------------------------------------------------------------
package jdi_pkg;

  // input beat: one quantized coefficient and its quantizer step
  typedef struct packed {
    logic signed [15:0] coef;
    logic [15:0]        quant;
  } in_t;

  // output beat: one pixel in raster order
  typedef struct packed {
    logic [7:0] pixel;
    logic [5:0] pixel_index;
    logic       block_end;
  } out_t;

  // queue entry: dequantized coefficient and its natural position
  typedef struct packed {
    logic [5:0]  addr;
    logic [31:0] value;
  } qent_t;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);

  localparam logic [5:0] ZZ_TO_NAT [64] = '{
     0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
    12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
    35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
    58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
  };

endpackage

FILE: rtl/jdi_front.sv
// ----------------------------------------------------------------------------
// jdi_front: coefficient intake
// Dequantizes each coefficient, maps zigzag to natural position, pushes it.
// ----------------------------------------------------------------------------
module jdi_front #(
  parameter int FRACTION_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  jdi_pkg::in_t  in_data_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output jdi_pkg::qent_t q_data_o
);

  logic [5:0]         zz_q, zz_d;
  logic signed [32:0] prod;
  logic [31:0]        prod32;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  // coef * quant, wrapped to 32 bits, then scaled
  assign prod   = in_data_i.coef * $signed({1'b0, in_data_i.quant});
  assign prod32 = prod[31:0];
  assign q_data_o.value = prod32 << (FRACTION_BITS - 3);
  assign q_data_o.addr  = jdi_pkg::ZZ_TO_NAT[zz_q];

  // zigzag position counter
  assign zz_d = q_push_o ? zz_q + 6'd1 : zz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zz_q <= '0;
    end else begin
      zz_q <= zz_d;
    end
  end

endmodule

FILE: rtl/jdi_fifo.sv
// ----------------------------------------------------------------------------
// jdi_fifo: short queue between intake and transform engine
// Registered storage, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module jdi_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  jdi_pkg::qent_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output jdi_pkg::qent_t data_o
);

  jdi_pkg::qent_t              mem_q [jdi_pkg::QDepth];
  logic [jdi_pkg::QPtrW-1:0]   wp_q, rp_q;
  logic [jdi_pkg::QPtrW:0]     cnt_q;
  logic                        do_pop;

  assign full_o  = (cnt_q == (jdi_pkg::QPtrW+1)'(jdi_pkg::QDepth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign do_pop  = pop_i & valid_o;

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (do_pop) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (jdi_pkg::QPtrW+1)'(push_i) - (jdi_pkg::QPtrW+1)'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

FILE: rtl/jdi_back.sv
// ----------------------------------------------------------------------------
// jdi_back: block store, 1-D IDCT sequencer and pixel output
// Loads 64 entries, runs 8 row and 8 column passes on one shared
// multiplier, then descales and emits pixels in raster order.
// ----------------------------------------------------------------------------
module jdi_back #(
  parameter int FRACTION_BITS = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  jdi_pkg::qent_t q_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output jdi_pkg::out_t  out_data_o
);

  typedef enum logic [2:0] {
    S_LOAD, S_RD, S_CALC, S_WR, S_OUT_RD, S_OUT_WAIT, S_OUT_HOLD
  } state_e;

  localparam logic [63:0] Giga = 64'd1000000000;
  localparam logic [63:0] Half = 64'd500000000;
  localparam logic signed [17:0] K0298 = 18'(((64'd298631336 << FRACTION_BITS) + Half) / Giga);
  localparam logic signed [17:0] K0390 = 18'(((64'd390180644 << FRACTION_BITS) + Half) / Giga);
  localparam logic signed [17:0] K0541 = 18'(((64'd541196100 << FRACTION_BITS) + Half) / Giga);
  localparam logic signed [17:0] K0765 = 18'(((64'd765366865 << FRACTION_BITS) + Half) / Giga);
  localparam logic signed [17:0] K0899 = 18'(((64'd899976223 << FRACTION_BITS) + Half) / Giga);
  localparam logic signed [17:0] K1175 = 18'(((64'd1175875602 << FRACTION_BITS) + Half) / Giga);
  localparam logic signed [17:0] K1501 = 18'(((64'd1501321110 << FRACTION_BITS) + Half) / Giga);
  localparam logic signed [17:0] K1847 = 18'(((64'd1847759065 << FRACTION_BITS) + Half) / Giga);
  localparam logic signed [17:0] K1961 = 18'(((64'd1961570560 << FRACTION_BITS) + Half) / Giga);
  localparam logic signed [17:0] K2053 = 18'(((64'd2053119869 << FRACTION_BITS) + Half) / Giga);
  localparam logic signed [17:0] K2562 = 18'(((64'd2562915447 << FRACTION_BITS) + Half) / Giga);
  localparam logic signed [17:0] K3072 = 18'(((64'd3072711026 << FRACTION_BITS) + Half) / Giga);

  state_e     state_q;
  logic       pass_q;
  logic [2:0] line_q;
  logic [3:0] cnt_q;
  logic [3:0] step_q;
  logic [5:0] ld_q;
  logic [5:0] pix_q;
  logic       out_valid_q;
  jdi_pkg::out_t out_q;

  logic [31:0] mem_q [64];
  logic [31:0] rdata_q;
  logic [5:0]  raddr, waddr, eaddr;
  logic [31:0] wdata;
  logic        we;

  logic [31:0] d_q [8];
  logic [31:0] t_q, sa_q, ec_q, ed_q, ea_q, eb_q;
  logic [31:0] s1_q, s2_q, s3_q, s4_q, s5_q;
  logic [31:0] q0_q, q1_q, q2_q, q3_q, r0_q, r1_q, r2_q, r3_q;
  logic [31:0] m_q;

  logic [31:0]        mul_a;
  logic signed [17:0] mul_c;
  logic signed [49:0] mul_p;
  logic signed [49:0] mul_s;

  logic [31:0]        rnd;
  logic signed [31:0] shv;
  logic signed [32:0] lvl;
  logic [7:0]         pix_val;

  assign q_pop_o     = (state_q == S_LOAD) & q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // element address within the current line: rows, then columns
  assign eaddr = pass_q ? {cnt_q[2:0], line_q} : {line_q, cnt_q[2:0]};
  assign raddr = (state_q == S_OUT_RD) ? pix_q : eaddr;

  // store write port
  always_comb begin
    we    = 1'b0;
    waddr = q_data_i.addr;
    wdata = q_data_i.value;
    if (state_q == S_LOAD) begin
      we = q_valid_i;
    end else if (state_q == S_WR) begin
      we    = 1'b1;
      waddr = eaddr;
      wdata = d_q[cnt_q[2:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= wdata;
    rdata_q <= mem_q[raddr];
  end

  // shared constant multiplier operand select
  always_comb begin
    mul_a = t_q;
    mul_c = '0;
    case (step_q)
      4'd1:  begin mul_a = t_q;    mul_c = K0541;  end
      4'd2:  begin mul_a = d_q[6]; mul_c = -K1847; end
      4'd3:  begin mul_a = d_q[2]; mul_c = K0765;  end
      4'd4:  begin mul_a = t_q;    mul_c = K1175;  end
      4'd5:  begin mul_a = d_q[7]; mul_c = K0298;  end
      4'd6:  begin mul_a = d_q[5]; mul_c = K2053;  end
      4'd7:  begin mul_a = d_q[3]; mul_c = K3072;  end
      4'd8:  begin mul_a = d_q[1]; mul_c = K1501;  end
      4'd9:  begin mul_a = s1_q;   mul_c = -K0899; end
      4'd10: begin mul_a = s2_q;   mul_c = -K2562; end
      4'd11: begin mul_a = s3_q;   mul_c = -K1961; end
      4'd12: begin mul_a = s4_q;   mul_c = -K0390; end
      default: begin mul_a = t_q;  mul_c = '0;     end
    endcase
  end

  assign mul_p = $signed(mul_a) * mul_c;
  assign mul_s = mul_p >>> FRACTION_BITS;

  // final descale, level shift and clamp
  assign rnd = rdata_q + (32'd1 << (FRACTION_BITS - 1));
  assign shv = $signed(rnd) >>> FRACTION_BITS;
  assign lvl = {shv[31], shv} + 33'sd128;
  always_comb begin
    if (lvl < 33'sd0)        pix_val = 8'd0;
    else if (lvl > 33'sd255) pix_val = 8'd255;
    else                     pix_val = lvl[7:0];
  end

  // sequencer state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      pass_q      <= 1'b0;
      line_q      <= '0;
      cnt_q       <= '0;
      step_q      <= '0;
      ld_q        <= '0;
      pix_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (q_valid_i) begin
            ld_q <= ld_q + 6'd1;
            if (ld_q == 6'd63) begin
              state_q <= S_RD;
              pass_q  <= 1'b0;
              line_q  <= '0;
              cnt_q   <= '0;
            end
          end
        end
        S_RD: begin
          if (cnt_q == 4'd8) begin
            state_q <= S_CALC;
            step_q  <= '0;
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_CALC: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'd15) begin
            state_q <= S_WR;
            cnt_q   <= '0;
          end
        end
        S_WR: begin
          if (cnt_q == 4'd7) begin
            cnt_q <= '0;
            if (line_q == 3'd7) begin
              line_q <= '0;
              if (!pass_q) begin
                pass_q  <= 1'b1;
                state_q <= S_RD;
              end else begin
                pix_q   <= '0;
                state_q <= S_OUT_RD;
              end
            end else begin
              line_q  <= line_q + 3'd1;
              state_q <= S_RD;
            end
          end else begin
            cnt_q <= cnt_q + 4'd1;
          end
        end
        S_OUT_RD: begin
          state_q <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          out_q.pixel       <= pix_val;
          out_q.pixel_index <= pix_q;
          out_q.block_end   <= (pix_q == 6'd63);
          out_valid_q       <= 1'b1;
          state_q           <= S_OUT_HOLD;
        end
        S_OUT_HOLD: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (pix_q == 6'd63) begin
              ld_q    <= '0;
              state_q <= S_LOAD;
            end else begin
              pix_q   <= pix_q + 6'd1;
              state_q <= S_OUT_RD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  // 1-D transform datapath
  always_ff @(posedge clk_i) begin
    m_q <= mul_s[31:0];
    if (state_q == S_RD && cnt_q != 4'd0) begin
      d_q[3'(cnt_q - 4'd1)] <= rdata_q;
    end
    if (state_q == S_CALC) begin
      case (step_q)
        4'd0: begin
          t_q  <= d_q[2] + d_q[6];
          ea_q <= d_q[0] + d_q[4];
          eb_q <= d_q[0] - d_q[4];
          s1_q <= d_q[7] + d_q[1];
          s2_q <= d_q[5] + d_q[3];
          s3_q <= d_q[7] + d_q[3];
          s4_q <= d_q[5] + d_q[1];
        end
        4'd1:  t_q  <= s3_q + s4_q;
        4'd2:  sa_q <= m_q;
        4'd3:  ec_q <= sa_q + m_q;
        4'd4:  ed_q <= sa_q + m_q;
        4'd5:  s5_q <= m_q;
        4'd6:  q0_q <= m_q;
        4'd7:  q1_q <= m_q;
        4'd8:  q2_q <= m_q;
        4'd9:  q3_q <= m_q;
        4'd10: s1_q <= m_q;
        4'd11: s2_q <= m_q;
        4'd12: s3_q <= m_q + s5_q;
        4'd13: begin
          s4_q <= m_q + s5_q;
          r0_q <= ea_q + ed_q;
          r3_q <= ea_q - ed_q;
          r1_q <= eb_q + ec_q;
          r2_q <= eb_q - ec_q;
        end
        4'd14: begin
          q0_q <= q0_q + s1_q + s3_q;
          q1_q <= q1_q + s2_q + s4_q;
          q2_q <= q2_q + s2_q + s3_q;
          q3_q <= q3_q + s1_q + s4_q;
        end
        default: begin
          d_q[0] <= r0_q + q3_q;
          d_q[7] <= r0_q - q3_q;
          d_q[1] <= r1_q + q2_q;
          d_q[6] <= r1_q - q2_q;
          d_q[2] <= r2_q + q1_q;
          d_q[5] <= r2_q - q1_q;
          d_q[3] <= r3_q + q0_q;
          d_q[4] <= r3_q - q0_q;
        end
      endcase
    end
  end

endmodule

FILE: rtl/jpeg_dequant_idct_8x8.sv
// ----------------------------------------------------------------------------
// jpeg_dequant_idct_8x8: dequantizing 8x8 slow-integer IDCT
// Intake dequantizes zigzag coefficients into a short queue; the engine
// loads them, runs row and column passes and emits raster pixels.
//
//   channel  | signals                          | beat
//   ---------+----------------------------------+---------------------------
//   in       | in_valid_i, in_stall_o, in_data_i | coef, quant (zigzag)
//   out      | out_valid_o, out_stall_i, out_data_o | pixel, index, block_end
//
// The engine pops a coefficient whenever it is in load and the queue is
// not empty. Each of the 16 line passes reads 8 elements, runs 16 steps
// on the single shared multiplier and writes 8 results; each pixel passes
// S_OUT_RD, S_OUT_WAIT and S_OUT_HOLD, which holds it while output stalls.
// Reset clears all control state; the block store needs no clearing.
// ----------------------------------------------------------------------------
module jpeg_dequant_idct_8x8 #(
  parameter int FRACTION_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  jdi_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output jdi_pkg::out_t out_data_o
);

  logic           q_full, q_push, q_valid, q_pop;
  jdi_pkg::qent_t q_wdata, q_rdata;

  jdi_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  jdi_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_rdata)
  );

  jdi_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_data_i    (q_rdata),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 8x8 dequantizing IDCT
// Streams zigzag coefficient blocks with random stalls on both channels,
// predicts every pixel with a bit-level model and checks each output beat.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 12;
  localparam int WATCHDOG_LIMIT = 200000;

  // fixed-point constants, rounded to FB fractional bits
  localparam longint K0298 = (64'd298631336  * (64'd1 << FB) + 500000000) / 1000000000;
  localparam longint K0390 = (64'd390180644  * (64'd1 << FB) + 500000000) / 1000000000;
  localparam longint K0541 = (64'd541196100  * (64'd1 << FB) + 500000000) / 1000000000;
  localparam longint K0765 = (64'd765366865  * (64'd1 << FB) + 500000000) / 1000000000;
  localparam longint K0899 = (64'd899976223  * (64'd1 << FB) + 500000000) / 1000000000;
  localparam longint K1175 = (64'd1175875602 * (64'd1 << FB) + 500000000) / 1000000000;
  localparam longint K1501 = (64'd1501321110 * (64'd1 << FB) + 500000000) / 1000000000;
  localparam longint K1847 = (64'd1847759065 * (64'd1 << FB) + 500000000) / 1000000000;
  localparam longint K1961 = (64'd1961570560 * (64'd1 << FB) + 500000000) / 1000000000;
  localparam longint K2053 = (64'd2053119869 * (64'd1 << FB) + 500000000) / 1000000000;
  localparam longint K2562 = (64'd2562915447 * (64'd1 << FB) + 500000000) / 1000000000;
  localparam longint K3072 = (64'd3072711026 * (64'd1 << FB) + 500000000) / 1000000000;

  // scoreboard: pixel predictor and queue of expected output beats
  class pixel_scoreboard;
    logic [31:0]    coef_store [64];
    int unsigned    zz_pos;
    jdi_pkg::out_t  pixel_queue[$];
    int             errors;
    int             pixels_checked;

    function new();
      zz_pos = 0;
      errors = 0;
      pixels_checked = 0;
    endfunction

    // constant product, floored, wrapped to 32 bits
    function automatic logic [31:0] cmul(logic [31:0] a, longint c);
      longint p;
      p = longint'($signed(a)) * c;
      return 32'(p >>> FB);
    endfunction

    // one 8-point slow-integer 1-D pass over v[base + k*st]
    function automatic void line_pass(ref logic [31:0] v[64], input int base, int st);
      logic [31:0] d[8];
      logic [31:0] sa, ea, eb, ec, ed, r0, r1, r2, r3;
      logic [31:0] q0, q1, q2, q3, s1, s2, s3, s4, s5;
      for (int k = 0; k < 8; k++) d[k] = v[base + k * st];
      sa = cmul(d[2] + d[6], K0541);
      ec = sa + cmul(d[6], -K1847);
      ed = sa + cmul(d[2], K0765);
      ea = d[0] + d[4];
      eb = d[0] - d[4];
      r0 = ea + ed; r3 = ea - ed;
      r1 = eb + ec; r2 = eb - ec;
      q0 = d[7]; q1 = d[5]; q2 = d[3]; q3 = d[1];
      s1 = q0 + q3; s2 = q1 + q2; s3 = q0 + q2; s4 = q1 + q3;
      s5 = cmul(s3 + s4, K1175);
      q0 = cmul(q0, K0298); q1 = cmul(q1, K2053);
      q2 = cmul(q2, K3072); q3 = cmul(q3, K1501);
      s1 = cmul(s1, -K0899); s2 = cmul(s2, -K2562);
      s3 = cmul(s3, -K1961) + s5;
      s4 = cmul(s4, -K0390) + s5;
      q0 = q0 + s1 + s3; q1 = q1 + s2 + s4;
      q2 = q2 + s2 + s3; q3 = q3 + s1 + s4;
      v[base]          = r0 + q3; v[base + 7 * st] = r0 - q3;
      v[base + st]     = r1 + q2; v[base + 6 * st] = r1 - q2;
      v[base + 2 * st] = r2 + q1; v[base + 5 * st] = r2 - q1;
      v[base + 3 * st] = r3 + q0; v[base + 4 * st] = r3 - q0;
    endfunction

    // note an accepted coefficient beat; the 64th one yields a block
    function void note_coef(jdi_pkg::in_t b);
      logic [31:0] w[64];
      logic [31:0] prod, t;
      int p;
      jdi_pkg::out_t e;
      prod = 32'(longint'(b.coef) * longint'({1'b0, b.quant}));
      coef_store[jdi_pkg::ZZ_TO_NAT[zz_pos]] = prod << (FB - 3);
      zz_pos = (zz_pos + 1) % 64;
      if (zz_pos != 0) return;
      w = coef_store;
      for (int i = 0; i < 8; i++) line_pass(w, i * 8, 1);
      for (int i = 0; i < 8; i++) line_pass(w, i, 8);
      for (int i = 0; i < 64; i++) begin
        t = w[i] + (32'd1 << (FB - 1));
        p = ($signed(t) >>> FB) + 128;
        if (p < 0) p = 0;
        if (p > 255) p = 255;
        e.pixel = 8'(p);
        e.pixel_index = 6'(i);
        e.block_end = (i == 63);
        pixel_queue.push_back(e);
      end
    endfunction

    // compare an accepted pixel beat with the oldest expectation
    function void check_pixel(jdi_pkg::out_t got);
      jdi_pkg::out_t e;
      if (pixel_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel beat %p", got);
        return;
      end
      e = pixel_queue.pop_front();
      pixels_checked++;
      if (got !== e) begin
        errors++;
        if (errors <= 10)
          $display("pixel mismatch: exp pix=%0d idx=%0d end=%0b, got pix=%0d idx=%0d end=%0b",
                   e.pixel, e.pixel_index, e.block_end,
                   got.pixel, got.pixel_index, got.block_end);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  jdi_pkg::in_t  in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  jdi_pkg::out_t out_data_o;

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int idle_cycles = 0;
  int coefs_sent = 0;
  pixel_scoreboard sb = new();

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  jpeg_dequant_idct_8x8 dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  // output side: random stall, check accepted beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_pixel(out_data_o);
      out_stall_i <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
        $display("watchdog expired");
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // send one coefficient beat, with random lead-in gap
  task automatic send_coef(logic signed [15:0] c, logic [15:0] q);
    jdi_pkg::in_t b;
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    b.coef = c;
    b.quant = q;
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_coef(b);
    coefs_sent++;
  endtask

  // random block: mostly sparse, small values; sometimes full-range
  task automatic send_random_block();
    int kind;
    logic signed [15:0] c;
    logic [15:0] q;
    kind = $urandom_range(9);
    for (int k = 0; k < 64; k++) begin
      if (kind < 6) begin
        c = (k < 10 || $urandom_range(3) == 0) ? 16'($signed($urandom_range(200)) - 100) : '0;
        q = 16'($urandom_range(1, 40));
      end else begin
        c = 16'($urandom);
        q = 16'($urandom);
      end
      send_coef(c, q);
    end
  endtask

  // stop sending and wait for every expected pixel
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (sb.pixel_queue.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extreme values with extreme quantizers
    src_idle_pct = 34; snk_idle_pct = 48;
    for (int k = 0; k < 64; k++)
      send_coef(k[0] ? 16'sh8000 : 16'sh7fff, (k % 3 == 0) ? 16'hffff : 16'd0);
    // pause until the block has fully drained
    wait_drained();

    src_idle_pct = 48; snk_idle_pct = 34;
    send_random_block();
    src_idle_pct = 0; snk_idle_pct = 0;
    send_random_block();

    wait_drained();
    repeat (50) @(posedge clk_i);
    $display("ran %0d coefficient beats, %0d pixels checked under mixed stall patterns",
             coefs_sent, sb.pixels_checked);
    if (sb.errors == 0 && sb.pixel_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

FILE: filelist.f
rtl/jdi_pkg.sv
rtl/jdi_front.sv
rtl/jdi_fifo.sv
rtl/jdi_back.sv
rtl/jpeg_dequant_idct_8x8.sv
dv/testbench.sv
